FILE: rtl/core/ads_pkg.sv
// Shared constants for the antialiased dot splat core.
`timescale 1ns / 1ps

package ads_pkg;

    // Field widths of the stream payloads
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 20;
    localparam int RC_W      = 8;
    localparam int VALUE_W   = 32;
    localparam int TOUCHED_W = 3;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 40;

    // Configuration register port
    localparam int CANVAS_W  = 9;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 9'd256;

    // Register indexes (taken from paddr[2])
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_SPLAT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Weight after scaling to 16 fraction bits (one unit is 2^16)
    localparam int WEIGHT_W = 17;

endpackage

FILE: rtl/core/ads_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module ads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one word per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ads_cfg.sv
// APB register bank holding the canvas width and height.
`timescale 1ns / 1ps

module ads_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ads_pkg::APB_AW-1:0]    paddr,
    input  logic [ads_pkg::APB_DW-1:0]    pwdata,
    output logic [ads_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [ads_pkg::CANVAS_W-1:0]  canvas_width,
    output logic [ads_pkg::CANVAS_W-1:0]  canvas_height
);

    logic [ads_pkg::CANVAS_W-1:0] width_reg;
    logic [ads_pkg::CANVAS_W-1:0] height_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Take a register write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ads_pkg::CANVAS_RESET;
            height_reg <= ads_pkg::CANVAS_RESET;
        end else if (wr_en) begin
            if (paddr[2] == ads_pkg::REG_CANVAS_WIDTH) begin
                width_reg <= pwdata[ads_pkg::CANVAS_W-1:0];
            end else begin
                height_reg <= pwdata[ads_pkg::CANVAS_W-1:0];
            end
        end
    end

    // Return the selected register
    always_comb begin
        if (paddr[2] == ads_pkg::REG_CANVAS_WIDTH) begin
            prdata = ads_pkg::APB_DW'(width_reg);
        end else begin
            prdata = ads_pkg::APB_DW'(height_reg);
        end
    end

    assign canvas_width  = width_reg;
    assign canvas_height = height_reg;

endmodule

FILE: rtl/core/ads_cell_unit.sv
// Shared cell unit: range check, store address and bilinear weight of one cell.
`timescale 1ns / 1ps

module ads_cell_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic signed [22-FRAC_BITS-1:0]            col,
    input  logic signed [22-FRAC_BITS-1:0]            row,
    input  logic [FRAC_BITS:0]                        wc,
    input  logic [FRAC_BITS:0]                        wr,
    input  logic [ads_pkg::CANVAS_W-1:0]              canvas_width,
    input  logic [ads_pkg::CANVAS_W-1:0]              canvas_height,
    output logic                                      hit,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   addr,
    output logic [ads_pkg::WEIGHT_W-1:0]              weight
);

    localparam int CMPW  = 22 - FRAC_BITS;
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PW    = 2 * FRAC_BITS + 2;
    localparam int SHR   = (2 * FRAC_BITS >= 16) ? 2 * FRAC_BITS - 16 : 0;
    localparam int SHL   = (2 * FRAC_BITS >= 16) ? 0 : 16 - 2 * FRAC_BITS;
    localparam logic [31:0] MAXW32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAXH32 = 32'(MAX_HEIGHT);

    logic [CMPW-2:0] col_u;
    logic [CMPW-2:0] row_u;
    logic [31:0]     col32;
    logic [31:0]     row32;
    logic [PW-1:0]   prod;
    logic [31:0]     prod32;
    logic [31:0]     addr32;

    assign col_u = col[CMPW-2:0];
    assign row_u = row[CMPW-2:0];
    assign col32 = 32'(col_u);
    assign row32 = 32'(row_u);

    // Skip cells left of, above, or beyond the effective canvas
    assign hit = !col[CMPW-1] && !row[CMPW-1]
              && (col32 < 32'(canvas_width))  && (col32 < MAXW32)
              && (row32 < 32'(canvas_height)) && (row32 < MAXH32);

    // Row-major store address
    assign addr32 = row32 * MAXW32 + col32;
    assign addr   = addr32[AW-1:0];

    // Axis weight product scaled to 16 fraction bits
    assign prod   = PW'(wc) * PW'(wr);
    assign prod32 = (2 * FRAC_BITS >= 16) ? (32'(prod) >> SHR) : (32'(prod) << SHL);
    assign weight = prod32[ads_pkg::WEIGHT_W-1:0];

endmodule

FILE: rtl/core/antialiased_dot_splat_core.sv
// Top level of the antialiased dot splat core: sequencer, store and stream ports.
`timescale 1ns / 1ps

// Accumulates bilinearly split unit dots into a store of MAX_WIDTH*MAX_HEIGHT
// 32-bit saturating cells held in one single-port RAM. Each item produces one
// result. Every splat and read access goes through that one RAM port and one
// shared cell unit (range check, address, weight multiply): a splat prepares
// its cells, then steps through four cells with an accumulate step for each
// in-range cell; a read looks up one cell and waits for its data; an unused
// code goes straight to its result; a clear sweeps the store to zero. A result
// that still waits on m_tready adds its wait to the next item. After reset the
// block sweeps the whole store and only then raises s_tready; configuration
// writes are taken throughout. A new item is accepted while the previous
// result still waits on m_tready.
module antialiased_dot_splat_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: x_pos[19:0], y_pos[39:20], read_col[47:40], read_row[55:48]
    input  logic [ads_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: func[1:0]
    input  logic [ads_pkg::FUNC_W-1:0]       s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: read_value[31:0], cells_touched[34:32], zero[39:35]
    output logic [ads_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ads_pkg::APB_AW-1:0]       paddr,
    input  logic [ads_pkg::APB_DW-1:0]       pwdata,
    output logic [ads_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = 21 - FRAC_BITS;
    localparam int CMPW  = IW + 1;
    localparam logic [20:0]        HALF = 21'(1 << (FRAC_BITS - 1));
    localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS + 1)'(1 << FRAC_BITS);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PREP   = 7'b0000010,
        ST_CELL   = 7'b0000100,
        ST_ACC    = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_CLR    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [ads_pkg::FUNC_W-1:0]          func_reg;
    logic [ads_pkg::POS_W-1:0]           x_reg, y_reg;
    logic [ads_pkg::RC_W-1:0]            rcol_reg, rrow_reg;
    logic signed [IW-1:0]                ix_reg, iy_reg;
    logic [FRAC_BITS-1:0]                fx_reg, fy_reg;
    logic [1:0]                          k_reg;
    logic [AW-1:0]                       cnt_reg;
    logic                                clr_op_reg;
    logic                                hit_reg;
    logic [AW-1:0]                       addr_reg;
    logic [ads_pkg::WEIGHT_W-1:0]        weight_reg;
    logic [ads_pkg::VALUE_W-1:0]         value_reg;
    logic [ads_pkg::TOUCHED_W-1:0]       touched_reg;
    logic                                m_valid_reg;
    logic [ads_pkg::M_DATA_W-1:0]        m_data_reg;

    logic [ads_pkg::CANVAS_W-1:0]        canvas_width, canvas_height;
    logic [20:0]                         bx, by;
    logic signed [CMPW-1:0]              cu_col, cu_row;
    logic [FRAC_BITS:0]                  cu_wc, cu_wr;
    logic                                cu_hit;
    logic [AW-1:0]                       cu_addr;
    logic [ads_pkg::WEIGHT_W-1:0]        cu_weight;
    logic                                ram_we;
    logic [AW-1:0]                       ram_addr;
    logic [ads_pkg::VALUE_W-1:0]         ram_wdata, ram_rdata;
    logic [ads_pkg::VALUE_W:0]           sum;
    logic                                s_fire, is_read, out_free;

    ads_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .canvas_width  (canvas_width),
        .canvas_height (canvas_height)
    );

    // Select the cell for the shared unit: read target or one of four splat cells
    assign is_read = (func_reg == ads_pkg::FUNC_READ);
    always_comb begin
        if (is_read) begin
            cu_col = $signed({{(CMPW - ads_pkg::RC_W){1'b0}}, rcol_reg});
            cu_row = $signed({{(CMPW - ads_pkg::RC_W){1'b0}}, rrow_reg});
        end else begin
            cu_col = $signed({ix_reg[IW-1], ix_reg}) + $signed(CMPW'(k_reg[0]));
            cu_row = $signed({iy_reg[IW-1], iy_reg}) + $signed(CMPW'(k_reg[1]));
        end
        cu_wc = k_reg[0] ? {1'b0, fx_reg} : ONE - {1'b0, fx_reg};
        cu_wr = k_reg[1] ? {1'b0, fy_reg} : ONE - {1'b0, fy_reg};
    end

    ads_cell_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
        .col           (cu_col),
        .row           (cu_row),
        .wc            (cu_wc),
        .wr            (cu_wr),
        .canvas_width  (canvas_width),
        .canvas_height (canvas_height),
        .hit           (cu_hit),
        .addr          (cu_addr),
        .weight        (cu_weight)
    );

    // Saturating accumulate of the fetched cell
    assign sum = {1'b0, ram_rdata} + (ads_pkg::VALUE_W + 1)'(weight_reg);

    // Store port: sweep on clear, write back on accumulate, else read
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = cu_addr;
        ram_wdata = sum[ads_pkg::VALUE_W] ? '1 : sum[ads_pkg::VALUE_W-1:0];
        case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg;
                ram_wdata = '0;
            end
            ST_ACC: begin
                ram_we   = 1'b1;
                ram_addr = addr_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ads_ram #(
        .WIDTH (ads_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Left edge of the dot in each axis
    assign bx = {x_reg[ads_pkg::POS_W-1], x_reg} - HALF;
    assign by = {y_reg[ads_pkg::POS_W-1], y_reg} - HALF;

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        ads_pkg::FUNC_SPLAT: state_next = ST_PREP;
                        ads_pkg::FUNC_READ:  state_next = ST_CELL;
                        ads_pkg::FUNC_CLEAR: state_next = ST_CLR;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_PREP: state_next = ST_CELL;
            ST_CELL: begin
                if (is_read) begin
                    state_next = ST_RDWAIT;
                end else if (cu_hit) begin
                    state_next = ST_ACC;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
            end
            ST_ACC:    state_next = (k_reg == 2'd3) ? ST_DONE : ST_CELL;
            ST_RDWAIT: state_next = ST_DONE;
            ST_CLR: begin
                if (cnt_reg == LAST_ADDR) begin
                    state_next = clr_op_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            clr_op_reg  <= 1'b0;
            k_reg       <= '0;
            touched_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Raise the result once the finishing step finds the output free, drop it once taken
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    k_reg       <= '0;
                    touched_reg <= '0;
                    cnt_reg     <= '0;
                    clr_op_reg  <= 1'b1;
                end
                ST_CELL: begin
                    if (!is_read && cu_hit) begin
                        touched_reg <= touched_reg + 3'd1;
                    end else if (!is_read) begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_ACC: begin
                    k_reg <= k_reg + 2'd1;
                end
                ST_CLR: begin
                    cnt_reg <= cnt_reg + AW'(1);
                end
                default: begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                func_reg  <= s_tuser;
                x_reg     <= s_tdata[19:0];
                y_reg     <= s_tdata[39:20];
                rcol_reg  <= s_tdata[47:40];
                rrow_reg  <= s_tdata[55:48];
                value_reg <= '0;
            end
            ST_PREP: begin
                ix_reg <= $signed(bx[20:FRAC_BITS]);
                iy_reg <= $signed(by[20:FRAC_BITS]);
                fx_reg <= bx[FRAC_BITS-1:0];
                fy_reg <= by[FRAC_BITS-1:0];
            end
            ST_CELL: begin
                hit_reg    <= cu_hit;
                addr_reg   <= cu_addr;
                weight_reg <= cu_weight;
            end
            ST_RDWAIT: begin
                value_reg <= hit_reg ? ram_rdata : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= {{(ads_pkg::M_DATA_W - ads_pkg::VALUE_W
                                     - ads_pkg::TOUCHED_W){1'b0}},
                                   touched_reg, value_reg};
                end
            end
            default: begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // No item is taken in the cycle after reset: the store sweep runs first
    a_boot_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("item accepted before the store sweep finished");

    // A new result appears only after the sequencer has finished an item
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finishing step");

    // A splat addresses at most four cells
    a_touched_max: assert property (@(posedge aclk) disable iff (!aresetn)
        touched_reg <= 3'd4)
        else $error("cell count passed four");

    // A store write-back only follows a cell step that hit the canvas
    a_acc_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> ($past(state_reg == ST_CELL) && hit_reg))
        else $error("accumulate without an in-range cell");

endmodule
